@@ rtl/core/bgdm_pkg.sv @@
// shared types and constants of the bridge gate duty modulator
`timescale 1ns / 1ps
`default_nettype none

package bgdm_pkg;

  // field widths of the stream beats
  localparam int unsigned IDX_W       = 6;
  localparam int unsigned VAL_W       = 12;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 16;
  localparam int unsigned RES_W       = 13;

  // duty, setpoint and slot widths
  localparam int unsigned DUTY_W = 4;
  localparam int unsigned SP_W   = 9;
  localparam int unsigned SLOT_W = 4;

  // channel sum scaling and store layout
  localparam int unsigned SUM_SHIFT = 7;
  localparam int unsigned NUM_CH    = 3;

  // configuration port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 9;

  // register reset values
  localparam logic [SP_W-1:0]   RST_VOLT_SP   = 9'd243;
  localparam logic [SP_W-1:0]   RST_CURR_SP   = 9'd85;
  localparam logic [DUTY_W-1:0] RST_DUTY_LIM  = 4'd5;
  localparam logic [SLOT_W-1:0] RST_SLOT_CNT  = 4'd10;

  // register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_SHUTDOWN      = 3'd0,
    CFG_CHARGE_EN     = 3'd1,
    CFG_OUTPUT_EN     = 3'd2,
    CFG_VOLT_SETPOINT = 3'd3,
    CFG_CURR_SETPOINT = 3'd4,
    CFG_DUTY_LIMIT    = 3'd5,
    CFG_SLOT_COUNT    = 3'd6
  } cfg_reg_t;

  // request kinds carried in tuser
  typedef enum logic {
    REQ_SAMPLE = 1'b0,
    REQ_TICK   = 1'b1
  } req_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SUM,
    ST_LAST,
    ST_DUTY,
    ST_EMIT,
    ST_WRAP
  } ctrl_state_t;

  // configuration register set
  typedef struct packed {
    logic              shutdown;
    logic              charge_en;
    logic              output_en;
    logic [SP_W-1:0]   volt_sp;
    logic [SP_W-1:0]   curr_sp;
    logic [DUTY_W-1:0] duty_limit;
    logic [SLOT_W-1:0] slot_count;
  } cfg_t;

  // one result beat, last field in the lowest bits
  typedef struct packed {
    logic [DUTY_W-1:0] out_duty_now;
    logic [DUTY_W-1:0] cap_duty_now;
    logic              fault_indicator;
    logic              out_leg_b;
    logic              out_leg_a;
    logic              cap_leg_b;
    logic              cap_leg_a;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/core/bgdm_store.sv @@
// sample store: one row of three channel lanes per sample slot, row valid bits
`timescale 1ns / 1ps
`default_nettype none

module bgdm_store #(
  parameter int unsigned ROWS   = 11,
  parameter int unsigned LANE_W = 12,
  parameter int unsigned RW     = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  rd_en,
  input  wire logic [RW-1:0]         rd_addr,
  input  wire logic                  wr_en,
  input  wire logic [RW-1:0]         wr_addr,
  input  wire logic [3*LANE_W-1:0]   wr_data,
  output logic      [3*LANE_W-1:0]   rd_data
);
  import bgdm_pkg::*;

  localparam int unsigned ROW_W = NUM_CH * LANE_W;

  logic [ROW_W-1:0] mem [ROWS];
  logic [ROWS-1:0]  valid_r;
  logic [ROW_W-1:0] rd_q_r;
  logic             rd_valid_r;

  // synchronous write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r     <= mem[rd_addr];
      rd_valid_r <= valid_r[rd_addr];
    end
  end

  // row valid bits, a row never written reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  assign rd_data = rd_valid_r ? rd_q_r : '0;

endmodule

`default_nettype wire

@@ rtl/core/bgdm_ctrl.sv @@
// request sequencer: sample write-back, channel sum sweep, duty update, leg drive
`timescale 1ns / 1ps
`default_nettype none

module bgdm_ctrl #(
  parameter int unsigned ROWS    = 11,
  parameter int unsigned ADC_BITS = 12,
  parameter int unsigned RW      = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire bgdm_pkg::cfg_t             cfg,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       in_kind,
  input  wire logic [bgdm_pkg::IDX_W-1:0] in_idx,
  input  wire logic [bgdm_pkg::VAL_W-1:0] in_val,
  output logic                            res_valid,
  input  wire logic                       res_ready,
  output bgdm_pkg::result_t               res,
  output logic                            mem_rd_en,
  output logic [RW-1:0]                   mem_rd_addr,
  output logic                            mem_wr_en,
  output logic [RW-1:0]                   mem_wr_addr,
  output logic [3*ADC_BITS-1:0]           mem_wr_data,
  input  wire logic [3*ADC_BITS-1:0]      mem_rd_data
);
  import bgdm_pkg::*;

  localparam int unsigned CNT_W = $clog2(ROWS + 1);
  localparam int unsigned SUM_W = ADC_BITS + $clog2(ROWS + 1);
  localparam int unsigned CW    = ((SUM_W > SP_W) ? SUM_W : SP_W) + 1;
  localparam int unsigned DEPTH = NUM_CH * ROWS;

  // setpoint minus scaled sum, clamped to 0..limit
  function automatic logic [DUTY_W-1:0] duty_from(input logic [SP_W-1:0] sp,
                                                   input logic [SUM_W-1:0] sum,
                                                   input logic [DUTY_W-1:0] lim);
    logic [CW-1:0] sh;
    logic [CW-1:0] spw;
    logic [CW-1:0] diff;
    sh   = CW'(sum >> SUM_SHIFT);
    spw  = CW'(sp);
    diff = spw - sh;
    if (sh > spw) begin
      return '0;
    end else if (diff > CW'(lim)) begin
      return lim;
    end else begin
      return diff[DUTY_W-1:0];
    end
  endfunction

  ctrl_state_t          state_r, state_nxt;
  logic                 slot_adv;
  logic [SLOT_W-1:0]    slot_r;
  logic                 phase_r;
  logic [DUTY_W-1:0]    cap_duty_r;
  logic [DUTY_W-1:0]    out_duty_r;
  logic                 res_valid_r;
  result_t              res_r;
  logic [RW-1:0]        row_r;
  logic [1:0]           lane_r;
  logic [ADC_BITS-1:0]  val_r;
  logic [CNT_W-1:0]     sweep_cnt_r;
  logic                 rd_pend_r;
  logic [SUM_W-1:0]     sum_r [NUM_CH];
  logic [SLOT_W:0]      wrap_r;

  logic                 accept;
  logic                 is_tick;
  logic [13:0]          idx_prod;
  logic [4:0]           row_calc;
  logic [IDX_W-1:0]     lane_calc;
  logic                 in_range;
  logic                 need_sum;
  logic                 out_free;
  logic                 last_issue;
  logic [SLOT_W:0]      slot_mod;
  logic [SLOT_W:0]      slot_inc;
  logic                 wrap_fits;
  logic [DUTY_W-1:0]    cap_calc;
  logic [DUTY_W-1:0]    outb_calc;
  logic [DUTY_W-1:0]    curr_calc;
  result_t              res_calc;
  logic                 load_res;

  // request decode: row is index / 3 by reciprocal, lane the remainder
  assign accept    = in_valid && in_ready;
  assign is_tick   = (req_t'(in_kind) == REQ_TICK);
  assign idx_prod  = 14'(in_idx) * 14'd171;
  assign row_calc  = idx_prod[13:9];
  assign lane_calc = in_idx - IDX_W'(row_calc) * IDX_W'(NUM_CH);
  assign in_range  = (in_idx < IDX_W'(DEPTH));

  // tick conditions
  assign need_sum   = !cfg.shutdown && (slot_r == '0) && !phase_r;
  assign out_free   = !res_valid_r || res_ready;
  assign last_issue = (sweep_cnt_r == CNT_W'(ROWS - 1));

  // slot counter wrap, a zero count wraps at sixteen
  assign slot_mod  = (cfg.slot_count == '0) ? 5'd16 : {1'b0, cfg.slot_count};
  assign slot_inc  = {1'b0, slot_r} + 5'd1;
  assign wrap_fits = (slot_inc < slot_mod);
  assign slot_adv  = !cfg.shutdown && phase_r;

  // duty update from the finished sums
  assign cap_calc  = duty_from(cfg.volt_sp, sum_r[0], cfg.duty_limit);
  assign outb_calc = duty_from(cfg.volt_sp, sum_r[1], cfg.duty_limit);
  assign curr_calc = duty_from(cfg.curr_sp, sum_r[2], cfg.duty_limit);

  // leg drive for the current tick
  always_comb begin
    res_calc = '0;
    res_calc.cap_duty_now = cap_duty_r;
    res_calc.out_duty_now = out_duty_r;
    if (cfg.shutdown) begin
      res_calc.fault_indicator = 1'b1;
    end else begin
      if (cfg.charge_en && (cap_duty_r > slot_r)) begin
        res_calc.cap_leg_a = !phase_r;
        res_calc.cap_leg_b = phase_r;
      end
      if (cfg.output_en && (out_duty_r > slot_r)) begin
        res_calc.out_leg_a = !phase_r;
        res_calc.out_leg_b = phase_r;
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (is_tick) begin
            state_nxt = need_sum ? ST_SUM : ST_EMIT;
          end else if (in_range) begin
            state_nxt = ST_WRITE;
          end
        end
      end
      ST_WRITE: state_nxt = ST_IDLE;
      ST_SUM: begin
        if (last_issue) begin
          state_nxt = ST_LAST;
        end
      end
      ST_LAST: state_nxt = ST_DUTY;
      ST_DUTY: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = (slot_adv && !wrap_fits) ? ST_WRAP : ST_IDLE;
        end
      end
      ST_WRAP: begin
        if (wrap_r < slot_mod) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs: handshake and memory port
  always_comb begin
    in_ready    = (state_r == ST_IDLE);
    mem_rd_en   = 1'b0;
    mem_rd_addr = row_calc[RW-1:0];
    mem_wr_en   = 1'b0;
    load_res    = 1'b0;
    unique case (state_r)
      ST_IDLE:  mem_rd_en = accept && !is_tick && in_range;
      ST_WRITE: mem_wr_en = 1'b1;
      ST_SUM: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = sweep_cnt_r[RW-1:0];
      end
      ST_EMIT:  load_res = out_free;
      ST_LAST, ST_DUTY, ST_WRAP: begin
      end
      default: begin
      end
    endcase
  end

  // merge the new sample into its row
  always_comb begin
    mem_wr_data = mem_rd_data;
    mem_wr_data[lane_r * ADC_BITS +: ADC_BITS] = val_r;
  end
  assign mem_wr_addr = row_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      slot_r      <= '0;
      phase_r     <= 1'b0;
      cap_duty_r  <= '0;
      out_duty_r  <= '0;
      res_valid_r <= 1'b0;
      rd_pend_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= (state_r == ST_SUM);
      if (state_r == ST_DUTY) begin
        cap_duty_r <= (curr_calc < cap_calc) ? curr_calc : cap_calc;
        out_duty_r <= outb_calc;
      end
      if (load_res) begin
        res_valid_r <= 1'b1;
      end else if (res_ready) begin
        res_valid_r <= 1'b0;
      end
      if (load_res && !cfg.shutdown) begin
        phase_r <= !phase_r;
        if (phase_r && wrap_fits) begin
          slot_r <= slot_inc[SLOT_W-1:0];
        end
      end
      if ((state_r == ST_WRAP) && (wrap_r < slot_mod)) begin
        slot_r <= wrap_r[SLOT_W-1:0];
      end
    end
  end

  // payload and sweep registers
  always_ff @(posedge clk) begin
    if (accept) begin
      row_r  <= row_calc[RW-1:0];
      lane_r <= lane_calc[1:0];
      val_r  <= ADC_BITS'(in_val);
    end
    if (state_r == ST_IDLE) begin
      sweep_cnt_r <= '0;
    end else if (state_r == ST_SUM) begin
      sweep_cnt_r <= sweep_cnt_r + CNT_W'(1);
    end
    for (int c = 0; c < NUM_CH; c++) begin
      if (state_r == ST_IDLE) begin
        sum_r[c] <= '0;
      end else if (rd_pend_r) begin
        sum_r[c] <= sum_r[c] + SUM_W'(mem_rd_data[c * ADC_BITS +: ADC_BITS]);
      end
    end
    if (load_res) begin
      res_r <= res_calc;
      if (slot_adv && !wrap_fits) begin
        wrap_r <= slot_inc - slot_mod;
      end
    end else if ((state_r == ST_WRAP) && (wrap_r >= slot_mod)) begin
      wrap_r <= wrap_r - slot_mod;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

`default_nettype wire

@@ rtl/core/bridge_gate_duty_modulator.sv @@
// a sample beat is stored by a row read and then a merged write-back; a tick beat
// goes to the emit state, where its result is registered once the output is free;
// on slot 0 phase 0 it first sweeps the sample store one row per cycle
// a slot counter wrap passes through the wrap state, which repeats when slot_count was lowered below it
// one beat in flight; the result register lets the next beat in while it waits
// reset: synchronous active low, sample rows read as zero until written
`timescale 1ns / 1ps
`default_nettype none

module bridge_gate_duty_modulator #(
  parameter int unsigned SAMPLES_PER_CHANNEL = 11,
  parameter int unsigned ADC_BITS            = 12
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  // sample_index, sample_value, zero pad
  input  wire logic [bgdm_pkg::IN_TDATA_W-1:0]       in_tdata,
  // req_type
  input  wire logic                                  in_tuser,
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  // cap_leg_a, cap_leg_b, out_leg_a, out_leg_b, fault_indicator,
  // cap_duty_now, out_duty_now, zero pad
  output logic [bgdm_pkg::OUT_TDATA_W-1:0]           out_tdata,
  input  wire logic                                  cfg_we,
  input  wire logic [bgdm_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  wire logic [bgdm_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
  import bgdm_pkg::*;

  localparam int unsigned RW = (SAMPLES_PER_CHANNEL > 1) ? $clog2(SAMPLES_PER_CHANNEL) : 1;

  cfg_t                   cfg_r;
  result_t                res;
  logic                   rd_en;
  logic [RW-1:0]          rd_addr;
  logic                   wr_en;
  logic [RW-1:0]          wr_addr;
  logic [3*ADC_BITS-1:0]  wr_data;
  logic [3*ADC_BITS-1:0]  rd_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.shutdown   <= 1'b0;
      cfg_r.charge_en  <= 1'b1;
      cfg_r.output_en  <= 1'b1;
      cfg_r.volt_sp    <= RST_VOLT_SP;
      cfg_r.curr_sp    <= RST_CURR_SP;
      cfg_r.duty_limit <= RST_DUTY_LIM;
      cfg_r.slot_count <= RST_SLOT_CNT;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_SHUTDOWN:      cfg_r.shutdown   <= cfg_wdata[0];
        CFG_CHARGE_EN:     cfg_r.charge_en  <= cfg_wdata[0];
        CFG_OUTPUT_EN:     cfg_r.output_en  <= cfg_wdata[0];
        CFG_VOLT_SETPOINT: cfg_r.volt_sp    <= cfg_wdata[SP_W-1:0];
        CFG_CURR_SETPOINT: cfg_r.curr_sp    <= cfg_wdata[SP_W-1:0];
        CFG_DUTY_LIMIT:    cfg_r.duty_limit <= cfg_wdata[DUTY_W-1:0];
        CFG_SLOT_COUNT:    cfg_r.slot_count <= cfg_wdata[SLOT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer
  bgdm_ctrl #(
    .ROWS     (SAMPLES_PER_CHANNEL),
    .ADC_BITS (ADC_BITS),
    .RW       (RW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_kind     (in_tuser),
    .in_idx      (in_tdata[IDX_W-1:0]),
    .in_val      (in_tdata[IDX_W+VAL_W-1:IDX_W]),
    .res_valid   (out_tvalid),
    .res_ready   (out_tready),
    .res         (res),
    .mem_rd_en   (rd_en),
    .mem_rd_addr (rd_addr),
    .mem_wr_en   (wr_en),
    .mem_wr_addr (wr_addr),
    .mem_wr_data (wr_data),
    .mem_rd_data (rd_data)
  );

  // sample store
  bgdm_store #(
    .ROWS   (SAMPLES_PER_CHANNEL),
    .LANE_W (ADC_BITS),
    .RW     (RW)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  assign out_tdata = {(OUT_TDATA_W - RES_W)'(0), res};

endmodule

`default_nettype wire

@@ rtl/core/bgdm_checker.sv @@
// port level checks of the bridge gate duty modulator, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module bgdm_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_tvalid,
  input wire logic                               in_tready,
  input wire logic                               in_tuser,
  input wire logic                               out_tvalid,
  input wire logic                               out_tready,
  input wire logic [bgdm_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  // reset empties the result register
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result beat valid after reset");

  // ready is low in the cycle after an accepted tick beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser) |=> !in_tready)
    else $error("ready held high right after an accepted tick beat");

  // a faulted beat drives no leg
  a_fault_legs_low: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[4]) |-> (out_tdata[3:0] == 4'b0000))
    else $error("leg driven while fault indicator set");

  // legs of one bridge never high together, a driven cap leg needs a nonzero duty
  a_legs_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!(out_tdata[0] && out_tdata[1]) && !(out_tdata[2] && out_tdata[3])
                    && (!(out_tdata[0] || out_tdata[1]) || (out_tdata[8:5] != 4'd0))))
    else $error("bridge legs inconsistent with duty");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result beat changed while stalled");

endmodule

bind bridge_gate_duty_modulator bgdm_checker u_bgdm_checker (.*);

`default_nettype wire
